[hw/rtl/pcte_pkg.sv]
// Shared types, codes and saturation helper for the cubic trajectory evaluator.
`default_nettype none

package pcte_pkg;

    localparam int DATA_W = 32;

    // input item kinds
    localparam logic [1:0] KIND_QUERY     = 2'd0;
    localparam logic [1:0] KIND_LOAD_MAIN = 2'd1;
    localparam logic [1:0] KIND_LOAD_DIV  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MAIN_COUNT = 3'd0;
    localparam logic [2:0] CFG_DIV_COUNT  = 3'd1;
    localparam logic [2:0] CFG_RESUME     = 3'd2;
    localparam logic [2:0] CFG_TIME_OFS   = 3'd3;
    localparam logic [2:0] CFG_SHIFT_X    = 3'd4;
    localparam logic [2:0] CFG_SHIFT_Y    = 3'd5;
    localparam logic [2:0] CFG_SHIFT_Z    = 3'd6;

    localparam logic [1:0] AXIS_YAW = 2'd3;

    // one axis of one segment, highest power first
    typedef struct packed {
        logic signed [DATA_W-1:0] c3;
        logic signed [DATA_W-1:0] c2;
        logic signed [DATA_W-1:0] c1;
        logic signed [DATA_W-1:0] c0;
    } t_coef_set;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pcte_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read.
`default_nettype none

module pcte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/pcte_horner.sv]
// Iterative Horner unit: one multiply and one add-saturate per coefficient.
`default_nettype none

module pcte_horner #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire pcte_pkg::t_coef_set     i_coef,
    input  wire logic signed [31:0]      i_t,
    output logic                         o_done,
    output logic signed [31:0]           o_result
);

    logic                r_busy;
    logic                r_phase;   // 0 multiply, 1 add
    logic [1:0]          r_step;
    logic                r_done;
    logic signed [31:0]  r_acc;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_t;
    pcte_pkg::t_coef_set r_coef;

    logic signed [31:0]  coef_next;
    logic signed [63:0]  prod_sh;
    logic signed [65:0]  sum;

    always_comb begin
        case (r_step)
            2'd1:    coef_next = r_coef.c2;
            2'd2:    coef_next = r_coef.c1;
            default: coef_next = r_coef.c0;
        endcase
        prod_sh = r_prod >>> FRACTION_BITS;   // floor
        sum     = 66'(prod_sh) + 66'(coef_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_step  <= 2'd1;
                r_acc   <= i_coef.c3;
                r_coef  <= i_coef;
                r_t     <= i_t;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_prod  <= r_acc * r_t;
                    r_phase <= 1'b1;
                end else begin
                    r_acc   <= pcte_pkg::f_sat32(sum);
                    r_phase <= 1'b0;
                    if (r_step == 2'd3) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

[hw/rtl/piecewise_cubic_trajectory_eval.sv]
// Top level: piecewise cubic trajectory evaluator over main and diversion segment tables.
//
// Usage notes
// - Input channel (i_in_valid / o_in_stall) carries one beat per item: a query
//   time (kind 0) or a load of one axis of one segment (kind 1 main, kind 2
//   diversion). Loads write the tables in the beat's own cycle and give no
//   result; kind 3 is dropped.
// - Output channel (o_out_valid / i_out_stall) carries one beat per query:
//   x, y, z, heading, the query time, segment index and two flags.
// - Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data);
//   the user must write it only while the block is idle; the block does not enforce this.
// - A query runs a binary search over the selected table, then evaluates the
//   four axes in turn; search and evaluation are skipped when the main path
//   is empty. The four axes share one iterative Horner unit, and items are
//   handled one at a time.
// - The finished beat sits in an output register, so a load or the next query
//   is taken while the receiver stalls; a second result waits until the first
//   has gone.
// - Reset (synchronous, active low) clears the configuration registers and
//   control state; table contents stay undefined until loaded.
`default_nettype none

module piecewise_cubic_trajectory_eval #(
    parameter int MAX_MAIN_SEGMENTS      = 64,
    parameter int MAX_DIVERSION_SEGMENTS = 32,
    parameter int FRACTION_BITS          = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [5:0]         i_seg_index,
    input  wire logic [1:0]         i_axis,
    input  wire logic signed [31:0] i_coef_cubic,
    input  wire logic signed [31:0] i_coef_square,
    input  wire logic signed [31:0] i_coef_linear,
    input  wire logic signed [31:0] i_coef_const,
    input  wire logic signed [31:0] i_start_time,
    input  wire logic signed [31:0] i_query_time,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_heading,
    output logic signed [31:0]      o_out_time,
    output logic [5:0]              o_segment_found,
    output logic                    o_on_diversion,
    output logic                    o_path_empty
);

    localparam int MIW  = $clog2(MAX_MAIN_SEGMENTS);
    localparam int DIW  = $clog2(MAX_DIVERSION_SEGMENTS);
    localparam int IW   = (MIW > DIW) ? MIW : DIW;
    localparam int SW   = IW + 2;              // signed search bounds, may reach -1
    localparam int MCAW = MIW + 2;
    localparam int DCAW = DIW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_SEL, S_SRCH_RD, S_SRCH_CMP, S_CRD, S_CSTART, S_HWAIT, S_OUT
    } t_state;

    // ---------------- configuration registers ----------------
    logic [6:0]         r_main_count;
    logic [5:0]         r_div_count;
    logic [5:0]         r_resume;
    logic signed [31:0] r_time_offset;
    logic signed [31:0] r_shift_x;
    logic signed [31:0] r_shift_y;
    logic signed [31:0] r_shift_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_count  <= '0;
            r_div_count   <= '0;
            r_resume      <= '0;
            r_time_offset <= '0;
            r_shift_x     <= '0;
            r_shift_y     <= '0;
            r_shift_z     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pcte_pkg::CFG_MAIN_COUNT: r_main_count  <= i_cfg_data[6:0];
                pcte_pkg::CFG_DIV_COUNT:  r_div_count   <= i_cfg_data[5:0];
                pcte_pkg::CFG_RESUME:     r_resume      <= i_cfg_data[5:0];
                pcte_pkg::CFG_TIME_OFS:   r_time_offset <= i_cfg_data;
                pcte_pkg::CFG_SHIFT_X:    r_shift_x     <= i_cfg_data;
                pcte_pkg::CFG_SHIFT_Y:    r_shift_y     <= i_cfg_data;
                pcte_pkg::CFG_SHIFT_Z:    r_shift_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- query/control registers ----------------
    t_state             r_state;
    logic signed [31:0] r_t;
    logic signed [31:0] r_off;
    logic signed [31:0] r_teval;
    logic               r_use_div;
    logic               r_shifted;
    logic               r_empty;
    logic signed [SW-1:0] r_low;
    logic signed [SW-1:0] r_high;
    logic [IW-1:0]      r_mid;
    logic [IW:0]        r_n;
    logic [1:0]         r_axis;
    logic signed [31:0] r_res [4];
    logic               r_out_valid;

    // ---------------- derived counts ----------------
    logic [31:0] nm32, nd32, lo32;
    logic [IW:0] nm, nd, nm_m1, nd_m1, lo, last_idx;

    always_comb begin
        nm32  = (32'(r_main_count) > 32'(MAX_MAIN_SEGMENTS)) ?
                32'(MAX_MAIN_SEGMENTS) : 32'(r_main_count);
        nd32  = (32'(r_div_count) > 32'(MAX_DIVERSION_SEGMENTS)) ?
                32'(MAX_DIVERSION_SEGMENTS) : 32'(r_div_count);
        nm    = nm32[IW:0];
        nd    = nd32[IW:0];
        nm_m1 = nm - (IW+1)'(1);
        nd_m1 = nd - (IW+1)'(1);
        // resume index clamps to the last valid main segment
        lo32  = (32'(r_resume) > nm32 - 32'd1) ? nm32 - 32'd1 : 32'(r_resume);
        lo    = lo32[IW:0];
        last_idx = r_n - (IW+1)'(1);
    end

    // ---------------- tables ----------------
    logic        in_acc;
    logic [31:0] seg32;
    logic        main_wr, div_wr;
    logic [SW-1:0] mid_sum;
    logic [IW-1:0] mid_c, mid_p1;

    logic [MIW-1:0] main_a_addr, main_b_addr;
    logic [DIW-1:0] div_a_addr, div_b_addr;
    logic [31:0]    main_a_q, main_b_q, div_a_q, div_b_q;
    pcte_pkg::t_coef_set wr_coef, main_coef_q, div_coef_q;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign seg32   = 32'(i_seg_index);
    assign main_wr = in_acc && (i_kind == pcte_pkg::KIND_LOAD_MAIN) &&
                     (seg32 < 32'(MAX_MAIN_SEGMENTS));
    assign div_wr  = in_acc && (i_kind == pcte_pkg::KIND_LOAD_DIV) &&
                     (seg32 < 32'(MAX_DIVERSION_SEGMENTS));
    assign wr_coef = '{c3: i_coef_cubic, c2: i_coef_square,
                       c1: i_coef_linear, c0: i_coef_const};

    assign mid_sum = SW'(r_low + r_high) >> 1;   // both bounds nonnegative here
    assign mid_c   = mid_sum[IW-1:0];
    assign mid_p1  = mid_c + IW'(1);

    // Outside the search the time ports fetch the range ends used by the
    // path selection: main last, diversion first and diversion last.
    always_comb begin
        main_a_addr = nm_m1[MIW-1:0];
        main_b_addr = '0;
        div_a_addr  = '0;
        div_b_addr  = nd_m1[DIW-1:0];
        if (r_state == S_SRCH_RD) begin
            main_a_addr = mid_c[MIW-1:0];
            main_b_addr = mid_p1[MIW-1:0];
            div_a_addr  = mid_c[DIW-1:0];
            div_b_addr  = mid_p1[DIW-1:0];
        end
    end

    pcte_ram #(.WIDTH(32), .DEPTH(MAX_MAIN_SEGMENTS)) u_main_time_a (
        .i_clk(i_clk), .i_wr_en(main_wr), .i_wr_addr(seg32[MIW-1:0]),
        .i_wr_data(i_start_time), .i_rd_addr(main_a_addr), .o_rd_data(main_a_q)
    );
    pcte_ram #(.WIDTH(32), .DEPTH(MAX_MAIN_SEGMENTS)) u_main_time_b (
        .i_clk(i_clk), .i_wr_en(main_wr), .i_wr_addr(seg32[MIW-1:0]),
        .i_wr_data(i_start_time), .i_rd_addr(main_b_addr), .o_rd_data(main_b_q)
    );
    pcte_ram #(.WIDTH(32), .DEPTH(MAX_DIVERSION_SEGMENTS)) u_div_time_a (
        .i_clk(i_clk), .i_wr_en(div_wr), .i_wr_addr(seg32[DIW-1:0]),
        .i_wr_data(i_start_time), .i_rd_addr(div_a_addr), .o_rd_data(div_a_q)
    );
    pcte_ram #(.WIDTH(32), .DEPTH(MAX_DIVERSION_SEGMENTS)) u_div_time_b (
        .i_clk(i_clk), .i_wr_en(div_wr), .i_wr_addr(seg32[DIW-1:0]),
        .i_wr_data(i_start_time), .i_rd_addr(div_b_addr), .o_rd_data(div_b_q)
    );
    pcte_ram #(.WIDTH(128), .DEPTH(MAX_MAIN_SEGMENTS*4)) u_main_coef (
        .i_clk(i_clk), .i_wr_en(main_wr), .i_wr_addr({seg32[MIW-1:0], i_axis}),
        .i_wr_data(wr_coef), .i_rd_addr(MCAW'({r_mid[MIW-1:0], r_axis})),
        .o_rd_data(main_coef_q)
    );
    pcte_ram #(.WIDTH(128), .DEPTH(MAX_DIVERSION_SEGMENTS*4)) u_div_coef (
        .i_clk(i_clk), .i_wr_en(div_wr), .i_wr_addr({seg32[DIW-1:0], i_axis}),
        .i_wr_data(wr_coef), .i_rd_addr(DCAW'({r_mid[DIW-1:0], r_axis})),
        .o_rd_data(div_coef_q)
    );

    // ---------------- Horner unit ----------------
    logic               h_done;
    logic signed [31:0] h_result;

    pcte_horner #(.FRACTION_BITS(FRACTION_BITS)) u_horner (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_CSTART),
        .i_coef(r_use_div ? div_coef_q : main_coef_q),
        .i_t(r_teval),
        .o_done(h_done),
        .o_result(h_result)
    );

    // ---------------- compares ----------------
    logic signed [33:0] t34, d_first, d_last, m_last_sh, a34, b34;
    logic signed [31:0] ta, tb, shift_sel, axis_val;
    logic signed [SW-1:0] mid_s;

    always_comb begin
        t34       = 34'(r_t);
        d_first   = 34'($signed(div_a_q));
        d_last    = 34'($signed(div_b_q));
        m_last_sh = 34'($signed(main_a_q)) - 34'(r_time_offset);
        ta        = r_use_div ? div_a_q : main_a_q;
        tb        = r_use_div ? div_b_q : main_b_q;
        a34       = 34'(ta) - 34'(r_off);
        b34       = 34'(tb) - 34'(r_off);
        mid_s     = $signed(SW'(r_mid));
        case (r_axis)
            2'd0:    shift_sel = r_shift_x;
            2'd1:    shift_sel = r_shift_y;
            default: shift_sel = r_shift_z;
        endcase
        axis_val = h_result;
        if (r_shifted && r_axis != pcte_pkg::AXIS_YAW) begin
            axis_val = pcte_pkg::f_sat32(66'(h_result) + 66'(shift_sel));
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT sets valid itself when it loads a new beat
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == pcte_pkg::KIND_QUERY) begin
                        r_t       <= i_query_time;
                        r_empty   <= 1'b0;
                        r_use_div <= 1'b0;
                        r_shifted <= 1'b0;
                        r_state   <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_axis <= 2'd0;
                    if (nm == '0) begin
                        r_empty <= 1'b1;
                        r_mid   <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_res[k] <= '0;
                        end
                        r_state <= S_OUT;
                    end else if (nd != '0 && t34 >= d_first && t34 <= d_last) begin
                        // diversion span
                        r_use_div <= 1'b1;
                        r_off     <= '0;
                        r_teval   <= r_t;
                        r_low     <= '0;
                        r_high    <= $signed(SW'(nd_m1));
                        r_n       <= nd;
                        r_mid     <= '0;
                        r_state   <= S_SRCH_RD;
                    end else if (nd != '0 && t34 > d_last && t34 <= m_last_sh) begin
                        // after the diversion: shifted main path from resume
                        r_shifted <= 1'b1;
                        r_off     <= r_time_offset;
                        r_teval   <= pcte_pkg::f_sat32(66'(r_t) + 66'(r_time_offset));
                        r_low     <= $signed(SW'(lo));
                        r_high    <= $signed(SW'(nm_m1));
                        r_n       <= nm;
                        r_mid     <= lo[IW-1:0];
                        r_state   <= S_SRCH_RD;
                    end else begin
                        r_off     <= '0;
                        r_teval   <= r_t;
                        r_low     <= '0;
                        r_high    <= $signed(SW'(nm_m1));
                        r_n       <= nm;
                        r_mid     <= '0;
                        r_state   <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (r_low <= r_high) begin
                        r_mid   <= mid_c;
                        r_state <= S_SRCH_CMP;
                    end else begin
                        r_state <= S_CRD;
                    end
                end
                S_SRCH_CMP: begin
                    if ((IW+1)'(r_mid) == last_idx) begin
                        r_state <= S_CRD;
                    end else if (t34 >= a34 && t34 < b34) begin
                        r_state <= S_CRD;
                    end else if (t34 < a34) begin
                        r_high  <= mid_s - SW'(1);
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_low   <= mid_s + SW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CSTART;       // coefficient read in flight
                end
                S_CSTART: begin
                    r_state <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (h_done) begin
                        r_res[r_axis] <= axis_val;
                        if (r_axis == pcte_pkg::AXIS_YAW) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_CRD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        o_pos_x         <= r_res[0];
                        o_pos_y         <= r_res[1];
                        o_pos_z         <= r_res[2];
                        o_heading       <= r_res[3];
                        o_out_time      <= r_t;
                        o_segment_found <= 6'(r_mid);
                        o_on_diversion  <= r_use_div;
                        o_path_empty    <= r_empty;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // ---------------- assertions ----------------
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_done |-> (r_state == S_HWAIT))
        else $error("Horner result outside its wait state");

    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> ((IW+1)'(r_mid) < r_n))
        else $error("search index beyond table count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_path_empty) |->
            (o_pos_x == 0 && o_heading == 0 && o_on_diversion == 1'b0))
        else $error("empty path result not zero");

    a_shift_not_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HWAIT) |-> !(r_shifted && r_use_div))
        else $error("shifted main and diversion both selected");

endmodule

`default_nettype wire

[test/piecewise_cubic_trajectory_eval_tb.sv]
// Testbench for the piecewise cubic trajectory evaluator: random loads and queries vs a predictor.
`default_nettype none

module piecewise_cubic_trajectory_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 100;

    // one input beat
    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  seg;
        logic [1:0]  axis;
        int          c3, c2, c1, c0;
        int          st;
        int          qt;
    } t_traj_item;

    // one output beat
    typedef struct {
        int          x, y, z, hdg, tm;
        logic [5:0]  seg;
        logic        div;
        logic        empty;
    } t_traj_pose;

    // Scoreboard: keeps its own copy of the tables and registers, predicts the
    // pose for every accepted query and compares output beats in order.
    class t_traj_scoreboard;
        int          main_t[64];
        int          main_c[1024];
        int          div_t[32];
        int          div_c[512];
        logic [6:0]  n_main;
        logic [5:0]  n_div;
        logic [5:0]  resume;
        longint      t_ofs, sh_x, sh_y, sh_z;
        t_traj_pose  expected_poses[$];
        int          errors;

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                pcte_pkg::CFG_MAIN_COUNT: n_main = v[6:0];
                pcte_pkg::CFG_DIV_COUNT:  n_div  = v[5:0];
                pcte_pkg::CFG_RESUME:     resume = v[5:0];
                pcte_pkg::CFG_TIME_OFS:   t_ofs  = longint'($signed(v));
                pcte_pkg::CFG_SHIFT_X:    sh_x   = longint'($signed(v));
                pcte_pkg::CFG_SHIFT_Y:    sh_y   = longint'($signed(v));
                pcte_pkg::CFG_SHIFT_Z:    sh_z   = longint'($signed(v));
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Horner with floor shift and saturation at every step
        function longint poly(bit use_main, int base, longint t);
            longint acc;
            acc = use_main ? main_c[base] : div_c[base];
            for (int k = 1; k < 4; k++)
                acc = clip32(((acc * t) >>> 16) +
                             longint'(use_main ? main_c[base+k] : div_c[base+k]));
            return acc;
        endfunction

        function int seg_search(bit use_main, int lo, int n, longint t, longint off);
            int low, high, mid;
            longint a, b;
            low = lo;
            high = n - 1;
            mid = lo;
            while (low <= high) begin
                mid = (low + high) / 2;
                if (mid == n - 1) break;
                a = longint'(use_main ? main_t[mid] : div_t[mid]) - off;
                b = longint'(use_main ? main_t[mid+1] : div_t[mid+1]) - off;
                if (t >= a && t < b) break;
                else if (t < a) high = mid - 1;
                else low = mid + 1;
            end
            return mid;
        endfunction

        function void note_item(t_traj_item it);
            t_traj_pose p;
            longint r[4];
            longint t, te;
            int nm, nd, found, lo;
            int base;
            if (it.kind == pcte_pkg::KIND_LOAD_MAIN || it.kind == pcte_pkg::KIND_LOAD_DIV) begin
                base = (int'(it.seg) * 4 + int'(it.axis)) * 4;
                if (it.kind == pcte_pkg::KIND_LOAD_MAIN) begin
                    main_c[base] = it.c3; main_c[base+1] = it.c2;
                    main_c[base+2] = it.c1; main_c[base+3] = it.c0;
                    main_t[it.seg] = it.st;
                end else if (it.seg < 32) begin
                    div_c[base] = it.c3; div_c[base+1] = it.c2;
                    div_c[base+2] = it.c1; div_c[base+3] = it.c0;
                    div_t[it.seg] = it.st;
                end
                return;
            end
            if (it.kind != pcte_pkg::KIND_QUERY) return;
            t = longint'(it.qt);
            nm = (n_main > 64) ? 64 : int'(n_main);
            nd = (n_div > 32) ? 32 : int'(n_div);
            found = 0;
            r = '{0, 0, 0, 0};
            p.div = 0;
            p.empty = 0;
            if (nm == 0) begin
                p.empty = 1;
            end else if (nd > 0 && t >= div_t[0] && t <= div_t[nd-1]) begin
                found = seg_search(0, 0, nd, t, 0);
                for (int k = 0; k < 4; k++) r[k] = poly(0, (found * 4 + k) * 4, t);
                p.div = 1;
            end else if (nd > 0 && t > div_t[nd-1] && t <= longint'(main_t[nm-1]) - t_ofs) begin
                // shifted main path after the diversion
                lo = (int'(resume) > nm - 1) ? nm - 1 : int'(resume);
                te = clip32(t + t_ofs);
                found = seg_search(1, lo, nm, t, t_ofs);
                for (int k = 0; k < 4; k++) r[k] = poly(1, (found * 4 + k) * 4, te);
                r[0] = clip32(r[0] + sh_x);
                r[1] = clip32(r[1] + sh_y);
                r[2] = clip32(r[2] + sh_z);
            end else begin
                found = seg_search(1, 0, nm, t, 0);
                for (int k = 0; k < 4; k++) r[k] = poly(1, (found * 4 + k) * 4, t);
            end
            p.x = int'(r[0]); p.y = int'(r[1]); p.z = int'(r[2]); p.hdg = int'(r[3]);
            p.tm = it.qt;
            p.seg = found[5:0];
            expected_poses = {expected_poses, p};
        endfunction

        function void check_beat(t_traj_pose a);
            t_traj_pose e;
            if (expected_poses.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output beat t=%0d", a.tm);
                return;
            end
            e = expected_poses.pop_front();
            if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.hdg !== e.hdg ||
                a.tm !== e.tm || a.seg !== e.seg || a.div !== e.div ||
                a.empty !== e.empty) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp x=%0d y=%0d z=%0d h=%0d t=%0d seg=%0d div=%0d emp=%0d",
                             e.x, e.y, e.z, e.hdg, e.tm, e.seg, e.div, e.empty);
                    $display("         got x=%0d y=%0d z=%0d h=%0d t=%0d seg=%0d div=%0d emp=%0d",
                             a.x, a.y, a.z, a.hdg, a.tm, a.seg, a.div, a.empty);
                end
            end
        endfunction
    endclass

    // DUT signals; the inputs are known from time zero
    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_wr_en = 0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [1:0]         i_kind = '0;
    logic [5:0]         i_seg_index = '0;
    logic [1:0]         i_axis = '0;
    logic signed [31:0] i_coef_cubic = '0;
    logic signed [31:0] i_coef_square = '0;
    logic signed [31:0] i_coef_linear = '0;
    logic signed [31:0] i_coef_const = '0;
    logic signed [31:0] i_start_time = '0;
    logic signed [31:0] i_query_time = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_heading, o_out_time;
    logic [5:0]         o_segment_found;
    logic               o_on_diversion, o_path_empty;

    piecewise_cubic_trajectory_eval dut (.*);

    t_traj_scoreboard sb = new();
    int  send_idle_pct = 0;    // sender gap odds per cycle, percent
    int  stall_pct = 0;        // receiver stall odds per cycle, percent
    int  hold_left = 0;        // long receiver hold-off, cycles left
    int  cycle_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("piecewise_cubic_trajectory_eval_tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // output monitor; values read here are those present at the edge
    always @(posedge i_clk) begin
        t_traj_pose a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            a.x = o_pos_x; a.y = o_pos_y; a.z = o_pos_z; a.hdg = o_heading;
            a.tm = o_out_time; a.seg = o_segment_found;
            a.div = o_on_diversion; a.empty = o_path_empty;
            sb.check_beat(a);
        end
    end

    // nominal start times: main segment i at 2.0*i s, diversion j at 10 + 0.5*j s
    function automatic int main_nom(int i);
        return i <<< 17;
    endfunction
    function automatic int div_nom(int j);
        return (10 <<< 16) + (j <<< 15);
    endfunction

    function automatic int rand_coef();
        if ($urandom_range(99) < 80) return int'($urandom_range(1 << 19)) - (1 << 18);
        return int'($urandom);
    endfunction

    function automatic t_traj_item load_item(logic [1:0] kind, int seg, int axis);
        t_traj_item it;
        it.kind = kind;
        it.seg = seg[5:0];
        it.axis = axis[1:0];
        it.c3 = rand_coef(); it.c2 = rand_coef(); it.c1 = rand_coef(); it.c0 = rand_coef();
        it.st = (kind == pcte_pkg::KIND_LOAD_MAIN) ? main_nom(seg) : div_nom(seg);
        if ($urandom_range(99) < 4) it.st = int'($urandom);   // the odd unsorted table
        it.qt = int'($urandom);
        return it;
    endfunction

    function automatic t_traj_item query_item(int qt);
        t_traj_item it;
        it.kind = pcte_pkg::KIND_QUERY;
        it.seg = 6'($urandom);
        it.axis = 2'($urandom);
        it.c3 = int'($urandom); it.c2 = int'($urandom);
        it.c1 = int'($urandom); it.c0 = int'($urandom);
        it.st = int'($urandom);
        it.qt = qt;
        return it;
    endfunction

    function automatic t_traj_item random_item();
        int r;
        int qt;
        t_traj_item it;
        r = $urandom_range(99);
        if (r < 2) begin
            it = query_item(0);
            it.kind = 2'd3;                       // unused kind, dropped
            return it;
        end
        if (r < 14)
            return load_item(pcte_pkg::KIND_LOAD_MAIN, $urandom_range(63), $urandom_range(3));
        if (r < 26)
            return load_item(pcte_pkg::KIND_LOAD_DIV, $urandom_range(63), $urandom_range(3));
        r = $urandom_range(99);
        if (r < 60) qt = int'($urandom_range(134 << 16)) - (4 << 16);
        else if (r < 75) qt = (10 << 16) + int'($urandom_range(16 << 16));
        else if (r < 85) qt = int'($urandom);
        else if (r < 93) qt = main_nom($urandom_range(63));
        else qt = div_nom($urandom_range(31));
        return query_item(qt);
    endfunction

    // one input beat; returns once accepted
    task automatic push_item(t_traj_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= it.kind;
        i_seg_index   <= it.seg;
        i_axis        <= it.axis;
        i_coef_cubic  <= it.c3;
        i_coef_square <= it.c2;
        i_coef_linear <= it.c1;
        i_coef_const  <= it.c0;
        i_start_time  <= it.st;
        i_query_time  <= it.qt;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    // wait for all poses, then let any in-flight work settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic cfg_all(int nm, int nd, int rs, int ofs, int sx, int sy, int sz);
        cfg_write(pcte_pkg::CFG_MAIN_COUNT, nm);
        cfg_write(pcte_pkg::CFG_DIV_COUNT, nd);
        cfg_write(pcte_pkg::CFG_RESUME, rs);
        cfg_write(pcte_pkg::CFG_TIME_OFS, ofs);
        cfg_write(pcte_pkg::CFG_SHIFT_X, sx);
        cfg_write(pcte_pkg::CFG_SHIFT_Y, sy);
        cfg_write(pcte_pkg::CFG_SHIFT_Z, sz);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) push_item(random_item());
        drain();
    endtask

    initial begin
        t_traj_item it;
        sb.set_reg(pcte_pkg::CFG_MAIN_COUNT, 0);
        sb.set_reg(pcte_pkg::CFG_DIV_COUNT, 0);
        sb.set_reg(pcte_pkg::CFG_RESUME, 0);
        sb.set_reg(pcte_pkg::CFG_TIME_OFS, 0);
        sb.set_reg(pcte_pkg::CFG_SHIFT_X, 0);
        sb.set_reg(pcte_pkg::CFG_SHIFT_Y, 0);
        sb.set_reg(pcte_pkg::CFG_SHIFT_Z, 0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty path: extreme query times, unused kind, out-of-range diversion load
        push_item(query_item(32'sh80000000));
        push_item(query_item(32'sh7fffffff));
        push_item(query_item(0));
        it = query_item(5);
        it.kind = 2'd3;
        push_item(it);
        push_item(load_item(pcte_pkg::KIND_LOAD_DIV, 40, 1));

        // fill both tables completely so no query ever reads an unwritten entry
        for (int s = 0; s < 64; s++)
            for (int a = 0; a < 4; a++) begin
                it = load_item(pcte_pkg::KIND_LOAD_MAIN, s, a);
                it.st = main_nom(s);
                push_item(it);
            end
        for (int s = 0; s < 32; s++)
            for (int a = 0; a < 4; a++) begin
                it = load_item(pcte_pkg::KIND_LOAD_DIV, s, a);
                it.st = div_nom(s);
                if (a == pcte_pkg::AXIS_YAW && s == 3) begin   // full-scale coefficients
                    it.c3 = 32'sh7fffffff; it.c2 = 32'sh80000000;
                    it.c1 = 32'sh7fffffff; it.c0 = 32'sh80000000;
                end
                push_item(it);
            end
        drain();

        cfg_all(64, 32, 20, 3 << 16, 5 << 16, -(7 << 16), 1 << 16);
        // directed queries: before first segment, diversion span and its ends,
        // shifted main path, past main end, time extremes
        push_item(query_item(32'sh80000000));
        push_item(query_item(-(1 << 16)));
        push_item(query_item(div_nom(0)));
        push_item(query_item(div_nom(3) + 100));
        push_item(query_item(div_nom(31)));
        push_item(query_item(div_nom(31) + 1));
        push_item(query_item(60 << 16));
        push_item(query_item(main_nom(63) - (3 << 16)));
        push_item(query_item(main_nom(63) - (3 << 16) + 1));
        push_item(query_item(main_nom(63)));
        push_item(query_item(32'sh7fffffff));
        drain();

        random_phase(150, 0, 0);

        cfg_all(10, 4, 63, -(2 << 16), 32'sh7fffffff, 32'sh80000000, 0);
        random_phase(150, 59, 0);

        cfg_all(1, 0, 0, 0, 0, 0, 0);
        random_phase(120, 0, 59);

        cfg_all(127, 63, 5, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, -1);
        random_phase(150, 37, 37);

        // long receiver hold-off while the sender keeps offering queries
        cfg_all(64, 32, 30, 32'sh7fffffff, 123, 456, 789);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (30) push_item(query_item(int'($urandom_range(130 << 16))));
        drain();
        random_phase(100, 0, 0);

        cfg_all(2, 2, 1, 1 << 16, 1 << 20, -(1 << 20), 3);
        random_phase(100, 59, 59);

        if (sb.expected_poses.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("piecewise_cubic_trajectory_eval_tb: clean");
        end else begin
            $display("piecewise_cubic_trajectory_eval_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
